// ===== rtl/umec_pkg.sv =====
// Package for the USB-MIDI event classifier with chord detection.
// Holds the item types, event and register codes, and the controller/datapath interface.
// No dependencies.
`default_nettype none

package umec_pkg;

  localparam int HELD_SLOTS = 10;
  localparam int HELD_IDX_W = $clog2(HELD_SLOTS);
  localparam int HELD_CNT_W = $clog2(HELD_SLOTS + 1);

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HOTKEY_ENABLE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOTKEY_NOTE_A   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOTKEY_NOTE_B   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT_MS = 8'd3;

  localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd5000;
  localparam logic [15:0] IDLE_MS_MAX        = 16'hFFFF;

  localparam logic [1:0] EV_NONE      = 2'd0;
  localparam logic [1:0] EV_NOTE_ON   = 2'd1;
  localparam logic [1:0] EV_NOTE_OFF  = 2'd2;
  localparam logic [1:0] EV_CTRL_CHG  = 2'd3;

  localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
  localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
  localparam logic [3:0] STATUS_CTRL_CHG = 4'hB;

  typedef struct packed {
    logic       kind;
    logic       first_in_transfer;
    logic [7:0] in_header;
    logic [7:0] in_status;
    logic [7:0] in_data1;
    logic [7:0] in_data2;
  } umec_in_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [3:0]  channel;
    logic [7:0]  note_or_control;
    logic [7:0]  event_value;
    logic        chord_hit;
    logic        link_connected;
    logic [31:0] note_on_total;
  } umec_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PRESS,
    ST_SCAN,
    ST_FIND,
    ST_DONE
  } umec_state_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic press;
    logic scan;
    logic find;
    logic load;
  } umec_cmd_t;

  typedef struct packed {
    logic press_req;
    logic release_req;
    logic idx_last;
    logic match;
    logic out_free;
  } umec_stat_t;

endpackage

`default_nettype wire

// ===== rtl/umec_ctrl.sv =====
// Controller state machine of the MIDI event classifier.
// Sequences decode, held-list append, scan and removal. Uses umec_pkg.
`default_nettype none

module umec_ctrl
  import umec_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire umec_stat_t stat,
  output umec_cmd_t       cmd
);

  umec_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (stat.press_req) state_next = ST_PRESS;
        else if (stat.release_req)   state_next = ST_FIND;
        else                         state_next = ST_DONE;
      end
      ST_PRESS: state_next = ST_SCAN;
      ST_SCAN: begin
        if (stat.idx_last) state_next = ST_DONE;
      end
      ST_FIND: begin
        if (stat.match || stat.idx_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        item_stall  = 1'b0;
        cmd.capture = item_valid;
      end
      ST_DECODE: cmd.decode = 1'b1;
      ST_PRESS:  cmd.press  = 1'b1;
      ST_SCAN:   cmd.scan   = 1'b1;
      ST_FIND:   cmd.find   = 1'b1;
      ST_DONE:   cmd.load   = stat.out_free;
      default:   cmd        = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/umec_dp.sv =====
// Datapath of the MIDI event classifier: configuration, link state, held-note list
// and the result register. Driven by umec_ctrl commands. Uses umec_pkg.
`default_nettype none

module umec_dp
  import umec_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire umec_in_t              item,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire umec_cmd_t             cmd,
  output umec_stat_t                 stat,
  output umec_out_t                  result,
  output logic                       result_valid,
  input  wire logic                  result_stall
);

  logic        hotkey_enable;
  logic [7:0]  hotkey_note_a;
  logic [7:0]  hotkey_note_b;
  logic [15:0] idle_timeout_ms;

  umec_in_t    it;
  logic        skip_rest;
  logic        connected;
  logic        activity_seen;
  logic [15:0] idle_ms;
  logic [31:0] note_on_count;

  logic [7:0]            held_notes [HELD_SLOTS];
  logic [HELD_CNT_W-1:0] held_count;
  logic [HELD_IDX_W-1:0] idx;
  logic                  has_a;
  logic                  has_b;
  logic                  chord_mode;

  logic [1:0] res_ev;
  logic [3:0] res_ch;
  logic [7:0] res_noc;
  logic [7:0] res_val;

  logic        detect_active;
  logic        skip_eff;
  logic        all_zero;
  logic        go;
  logic [3:0]  msg_type;
  logic        is_note_on;
  logic        is_note_off;
  logic        is_ctrl;
  logic [1:0]  ev;
  logic [15:0] idle_inc;
  logic [7:0]  cur_note;

  always_ff @(posedge clk) begin
    if (rst) begin
      hotkey_enable   <= 1'b0;
      hotkey_note_a   <= '0;
      hotkey_note_b   <= '0;
      idle_timeout_ms <= IDLE_TIMEOUT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HOTKEY_ENABLE:   hotkey_enable   <= cfg_data[0];
        CFG_HOTKEY_NOTE_A:   hotkey_note_a   <= cfg_data[7:0];
        CFG_HOTKEY_NOTE_B:   hotkey_note_b   <= cfg_data[7:0];
        CFG_IDLE_TIMEOUT_MS: idle_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  assign detect_active = hotkey_enable && (hotkey_note_a != '0) && (hotkey_note_b != '0);
  assign skip_eff      = skip_rest && !it.first_in_transfer;
  assign all_zero      = (it.in_header == '0) && (it.in_status == '0) &&
                         (it.in_data1 == '0) && (it.in_data2 == '0);
  assign go            = !it.kind && !skip_eff && !all_zero && (it.in_header[3:0] != '0);
  assign msg_type      = it.in_status[7:4];
  assign is_note_on    = (msg_type == STATUS_NOTE_ON) && (it.in_data2 != '0);
  assign is_note_off   = (msg_type == STATUS_NOTE_OFF) ||
                         ((msg_type == STATUS_NOTE_ON) && (it.in_data2 == '0));
  assign is_ctrl       = (msg_type == STATUS_CTRL_CHG);
  assign idle_inc      = (idle_ms == IDLE_MS_MAX) ? idle_ms : idle_ms + 16'd1;
  assign cur_note      = held_notes[idx];

  always_comb begin
    ev = EV_NONE;
    if (go) begin
      priority if (is_note_on) ev = EV_NOTE_ON;
      else if (is_note_off)    ev = EV_NOTE_OFF;
      else if (is_ctrl)        ev = EV_CTRL_CHG;
      else                     ev = EV_NONE;
    end
  end

  always_comb begin
    stat.press_req   = go && is_note_on && detect_active;
    stat.release_req = go && is_note_off && detect_active && (held_count != '0);
    stat.idx_last    = (HELD_CNT_W'(idx) + HELD_CNT_W'(1)) == held_count;
    stat.match       = (cur_note == it.in_data1);
    stat.out_free    = !result_valid || !result_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_rest     <= 1'b0;
      connected     <= 1'b0;
      activity_seen <= 1'b0;
      idle_ms       <= '0;
      note_on_count <= '0;
      held_count    <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (cmd.decode) begin
        if (it.kind) begin
          if (activity_seen) begin
            idle_ms <= idle_inc;
            if (idle_inc > idle_timeout_ms) connected <= 1'b0;
          end
        end else begin
          skip_rest <= !it.first_in_transfer && (skip_rest || all_zero);
          if (go) begin
            connected     <= 1'b1;
            activity_seen <= 1'b1;
            idle_ms       <= '0;
            if (is_note_on) note_on_count <= note_on_count + 32'd1;
          end
        end
      end
      if (cmd.press && (held_count < HELD_CNT_W'(HELD_SLOTS))) begin
        held_count <= held_count + HELD_CNT_W'(1);
      end
      if (cmd.find && stat.match) begin
        held_count <= held_count - HELD_CNT_W'(1);
      end
      if (cmd.load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) it <= item;
    if (cmd.decode) begin
      idx        <= '0;
      has_a      <= 1'b0;
      has_b      <= 1'b0;
      chord_mode <= 1'b0;
      res_ev     <= ev;
      res_ch     <= (ev != EV_NONE) ? it.in_status[3:0] : 4'd0;
      res_noc    <= (ev != EV_NONE) ? it.in_data1 : 8'd0;
      res_val    <= (ev != EV_NONE) ? it.in_data2 : 8'd0;
    end
    if (cmd.press) begin
      chord_mode <= 1'b1;
      if (held_count < HELD_CNT_W'(HELD_SLOTS)) begin
        held_notes[held_count[HELD_IDX_W-1:0]] <= it.in_data1;
      end
    end
    if (cmd.scan) begin
      if (cur_note == hotkey_note_a) has_a <= 1'b1;
      if (cur_note == hotkey_note_b) has_b <= 1'b1;
      if (!stat.idx_last) idx <= idx + HELD_IDX_W'(1);
    end
    if (cmd.find) begin
      if (stat.match) begin
        for (int k = 0; k < HELD_SLOTS - 1; k++) begin
          if (HELD_IDX_W'(k) >= idx) held_notes[k] <= held_notes[k + 1];
        end
      end else if (!stat.idx_last) begin
        idx <= idx + HELD_IDX_W'(1);
      end
    end
    if (cmd.load) begin
      result.event_res       <= res_ev;
      result.channel         <= res_ch;
      result.note_or_control <= res_noc;
      result.event_value     <= res_val;
      result.chord_hit       <= chord_mode && has_a && has_b;
      result.link_connected  <= connected;
      result.note_on_total   <= note_on_count;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/usb_midi_event_classifier_chord_top.sv =====
// Flow: an accepted item is decoded; while chord detection is active, a note on is appended
// to the held list, which is then scanned one entry per cycle, and a note off is searched for
// in the list and removed. The result is then loaded into the output register, and a new item
// is taken only after that load, which waits while the output is stalled.
// Reset (rst, synchronous): clears the state machine, link state, counters, held count and
// configuration; held-note entries are not cleared. Top level; uses umec_pkg.
`default_nettype none

module usb_midi_event_classifier_chord_top
  import umec_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire umec_in_t              item,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output umec_out_t                  result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  umec_cmd_t  cmd;
  umec_stat_t stat;

  assign cfg_ready = 1'b1;

  umec_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  umec_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

`default_nettype wire

// ===== rtl/umec_checker.sv =====
// Port-level checker for the MIDI event classifier, bound to the top level.
// Uses umec_pkg.
`default_nettype none

module umec_checker
  import umec_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      item_valid,
  input wire logic      item_stall,
  input wire logic      result_valid,
  input wire logic      result_stall,
  input wire umec_out_t result
);

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("Stalled result item was dropped.");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("Stalled result item changed.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("Block accepted a second item while the first was in work.");

  a_none_is_blank: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.event_res == EV_NONE) |->
      (result.channel == '0) && (result.note_or_control == '0) &&
      (result.event_value == '0))
    else $error("Result item without an event carries payload bytes.");

  a_chord_only_on_note_on: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.chord_hit |-> result.event_res == EV_NOTE_ON)
    else $error("Chord flagged on an item that is not a note on.");

endmodule

bind usb_midi_event_classifier_chord_top umec_checker u_umec_checker (.*);

`default_nettype wire

// ===== verif/usb_midi_event_classifier_chord_top_tb.sv =====
// Self-checking testbench for usb_midi_event_classifier_chord_top: packets and ticks go in
// through a driver queue, and a monitor checks each result against an in-bench predictor.
// Depends on umec_pkg and the top-level RTL.
module usb_midi_event_classifier_chord_top_tb;
  import umec_pkg::*;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_TICK   = 1'b1;
  localparam logic [3:0] CIN_NONE = 4'h0;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  umec_in_t              item = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  umec_out_t             result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  umec_in_t  pending_items[$];
  umec_out_t expected_events[$];
  umec_out_t want;
  logic      item_fire = 1'b0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        recv_hold_left = 0;
  int        mismatches = 0;

  logic        cfg_enable = 1'b0;
  logic [7:0]  cfg_note_a = 8'd0;
  logic [7:0]  cfg_note_b = 8'd0;
  logic [15:0] cfg_timeout = IDLE_TIMEOUT_RESET;

  logic        skip_to_next_xfer = 1'b0;
  logic        link_up = 1'b0;
  logic        link_seen = 1'b0;
  logic [15:0] idle_ms_cnt = 16'd0;
  logic [31:0] note_on_cnt = 32'd0;
  logic [7:0]  held_list[HELD_SLOTS];
  int          held_n = 0;

  usb_midi_event_classifier_chord_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic umec_out_t classify_item(input umec_in_t it);
    umec_out_t r;
    logic      go;
    logic      armed;
    logic      has_a;
    logic      has_b;
    int        i;
    int        pos;
    r = '0;
    armed = cfg_enable && cfg_note_a != 8'd0 && cfg_note_b != 8'd0;
    if (it.kind == KIND_TICK) begin
      if (link_seen) begin
        if (idle_ms_cnt != IDLE_MS_MAX) idle_ms_cnt++;
        if (idle_ms_cnt > cfg_timeout) link_up = 1'b0;
      end
    end else begin
      go = 1'b1;
      if (it.first_in_transfer) skip_to_next_xfer = 1'b0;
      if (skip_to_next_xfer) begin
        go = 1'b0;
      end else if ({it.in_header, it.in_status, it.in_data1, it.in_data2} == 32'd0) begin
        if (!it.first_in_transfer) skip_to_next_xfer = 1'b1;
        go = 1'b0;
      end else if (it.in_header[3:0] == CIN_NONE) begin
        go = 1'b0;
      end
      if (go) begin
        link_up = 1'b1;
        link_seen = 1'b1;
        idle_ms_cnt = 16'd0;
        if (it.in_status[7:4] == STATUS_NOTE_ON && it.in_data2 != 8'd0) begin
          r.event_res = EV_NOTE_ON;
          note_on_cnt++;
          if (armed) begin
            if (held_n < HELD_SLOTS) begin
              held_list[held_n] = it.in_data1;
              held_n++;
            end
            has_a = 1'b0;
            has_b = 1'b0;
            for (i = 0; i < held_n; i++) begin
              if (held_list[i] == cfg_note_a) has_a = 1'b1;
              if (held_list[i] == cfg_note_b) has_b = 1'b1;
            end
            r.chord_hit = has_a && has_b;
          end
        end else if (it.in_status[7:4] == STATUS_NOTE_ON ||
                     it.in_status[7:4] == STATUS_NOTE_OFF) begin
          r.event_res = EV_NOTE_OFF;
          if (armed) begin
            pos = -1;
            for (i = 0; i < held_n; i++)
              if (pos < 0 && held_list[i] == it.in_data1) pos = i;
            if (pos >= 0) begin
              for (i = pos; i < held_n - 1; i++) held_list[i] = held_list[i + 1];
              held_n--;
            end
          end
        end else if (it.in_status[7:4] == STATUS_CTRL_CHG) begin
          r.event_res = EV_CTRL_CHG;
        end
      end
    end
    if (r.event_res != EV_NONE) begin
      r.channel = it.in_status[3:0];
      r.note_or_control = it.in_data1;
      r.event_value = it.in_data2;
    end
    r.link_connected = link_up;
    r.note_on_total = note_on_cnt;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_v);
    if (got !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    item_fire = item_valid && !item_stall;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HOTKEY_ENABLE:   cfg_enable = cfg_data[0];
          CFG_HOTKEY_NOTE_A:   cfg_note_a = cfg_data[7:0];
          CFG_HOTKEY_NOTE_B:   cfg_note_b = cfg_data[7:0];
          CFG_IDLE_TIMEOUT_MS: cfg_timeout = cfg_data;
          default: ;
        endcase
      end
      if (item_fire) expected_events.push_back(classify_item(item));
      if (result_valid && !result_stall) begin
        if (expected_events.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual %p",
                   $time, result);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_res", result.event_res, want.event_res);
          check_field("channel", result.channel, want.channel);
          check_field("note_or_control", result.note_or_control, want.note_or_control);
          check_field("event_value", result.event_value, want.event_value);
          check_field("chord_hit", result.chord_hit, want.chord_hit);
          check_field("link_connected", result.link_connected, want.link_connected);
          check_field("note_on_total", result.note_on_total, want.note_on_total);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst && !(item_valid && !item_fire)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (recv_hold_left > 0) begin
      result_stall <= 1'b1;
      recv_hold_left--;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic en, input logic [7:0] note_a, input logic [7:0] note_b,
                            input logic [15:0] timeout);
    write_reg(CFG_HOTKEY_ENABLE, {15'($urandom), en});
    write_reg(CFG_HOTKEY_NOTE_A, {8'($urandom), note_a});
    write_reg(CFG_HOTKEY_NOTE_B, {8'($urandom), note_b});
    write_reg(CFG_IDLE_TIMEOUT_MS, timeout);
  endtask

  task automatic send_packet(input logic first, input logic [7:0] hdr, input logic [7:0] st,
                             input logic [7:0] d1, input logic [7:0] d2);
    umec_in_t it;
    it.kind = KIND_PACKET;
    it.first_in_transfer = first;
    it.in_header = hdr;
    it.in_status = st;
    it.in_data1 = d1;
    it.in_data2 = d2;
    pending_items.push_back(it);
  endtask

  task automatic send_tick();
    umec_in_t it;
    it = {KIND_TICK, 1'($urandom_range(1)), 32'($urandom)};
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || item_valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic queue_random_items(input int n);
    int         sel;
    int         burst;
    logic       first;
    logic [7:0] hdr;
    logic [7:0] note;
    logic [3:0] ch;
    repeat (n) begin
      sel = $urandom_range(99);
      first = ($urandom_range(3) == 0);
      hdr = {4'($urandom), 4'($urandom_range(1, 15))};
      ch = 4'($urandom);
      case ($urandom_range(3))
        0: note = cfg_note_a;
        1: note = cfg_note_b;
        2: note = 8'(48 + $urandom_range(3));
        default: note = 8'($urandom);
      endcase
      if (sel < 12) begin
        burst = (cfg_timeout < 16'd30) ? int'(cfg_timeout) + 2 : 6;
        repeat ($urandom_range(1, burst)) send_tick();
      end else if (sel < 15) begin
        send_packet(1'($urandom_range(1)), 8'h00, 8'h00, 8'h00, 8'h00);
      end else if (sel < 18) begin
        send_packet(first, {4'($urandom), CIN_NONE}, 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (sel < 24) begin
        send_packet(first, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (sel < 62) begin
        send_packet(first, hdr, {STATUS_NOTE_ON, ch}, note, 8'($urandom_range(1, 255)));
      end else if (sel < 80) begin
        send_packet(first, hdr, {STATUS_NOTE_OFF, ch}, note, 8'($urandom));
      end else if (sel < 88) begin
        send_packet(first, hdr, {STATUS_NOTE_ON, ch}, note, 8'h00);
      end else if (sel < 95) begin
        send_packet(first, hdr, {STATUS_CTRL_CHG, ch}, 8'($urandom), 8'($urandom));
      end else begin
        send_packet(first, hdr, 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    int p;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_tick();
    send_packet(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    send_packet(1'b0, 8'h20, {STATUS_NOTE_ON, 4'h0}, 8'd60, 8'd100);
    send_packet(1'b1, 8'hF9, {STATUS_NOTE_ON, 4'hF}, 8'hFF, 8'hFF);
    send_packet(1'b0, 8'h09, {STATUS_NOTE_ON, 4'h0}, 8'h00, 8'h00);
    send_packet(1'b0, 8'h08, {STATUS_NOTE_OFF, 4'h5}, 8'd60, 8'd64);
    send_packet(1'b0, 8'h0B, {STATUS_CTRL_CHG, 4'h3}, 8'd7, 8'd127);
    send_packet(1'b0, 8'h0E, 8'hE0, 8'd0, 8'd64);
    send_packet(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_packet(1'b0, 8'h09, {STATUS_NOTE_ON, 4'h1}, 8'd60, 8'd90);
    send_packet(1'b1, 8'h09, {STATUS_NOTE_ON, 4'h1}, 8'd60, 8'd90);
    send_tick();
    wait_drained();

    set_config(1'b1, 8'd60, 8'd64, 16'd0);
    send_packet(1'b1, 8'h09, {STATUS_NOTE_ON, 4'h0}, 8'd60, 8'd100);
    send_packet(1'b0, 8'h09, {STATUS_NOTE_ON, 4'h0}, 8'd64, 8'd100);
    send_packet(1'b0, 8'h08, {STATUS_NOTE_OFF, 4'h0}, 8'd60, 8'd0);
    send_packet(1'b0, 8'h09, {STATUS_NOTE_ON, 4'h0}, 8'd60, 8'd1);
    send_tick();
    send_packet(1'b1, 8'h08, {STATUS_NOTE_OFF, 4'h0}, 8'd99, 8'd10);
    for (p = 0; p < 8; p++)
      send_packet(1'b0, 8'h09, {STATUS_NOTE_ON, 4'h2}, 8'(40 + p), 8'd80);
    send_packet(1'b0, 8'h09, {STATUS_NOTE_ON, 4'h2}, 8'd64, 8'd80);
    send_packet(1'b0, 8'h09, {STATUS_NOTE_ON, 4'h2}, 8'd64, 8'd0);
    wait_drained();

    write_reg(8'd4, 16'($urandom));
    write_reg(8'hFF, 16'($urandom));

    for (p = 0; p < 8; p++) begin
      case (p)
        0: set_config(1'b1, 8'd60, 8'd64, 16'd3);
        1: set_config(1'b1, 8'd255, 8'd255, 16'd1);
        2: set_config(1'b1, 8'd0, 8'd64, 16'd10);
        3: set_config(1'b0, 8'd60, 8'd62, 16'd0);
        4: set_config(1'b1, 8'd1, 8'd127, 16'hFFFF);
        5: set_config(1'b1, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                      16'($urandom_range(30)));
        6: set_config(1'b1, 8'd60, 8'd64, 16'd7);
        default: set_config(1'($urandom_range(1)), 8'($urandom), 8'($urandom),
                            16'($urandom_range(1, 50)));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      queue_random_items(70);
      wait_drained();
      queue_random_items(70);
      wait_drained();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold_left = 300;
    queue_random_items(80);
    wait_drained();

    set_config(1'($urandom_range(1)), 8'd60, 8'd64, 16'hFFFF);
    send_packet(1'b1, 8'h19, {STATUS_NOTE_ON, 4'h7}, 8'd64, 8'd50);
    repeat (20) send_tick();
    send_packet(1'b1, 8'h19, {STATUS_NOTE_OFF, 4'h7}, 8'd64, 8'd50);
    send_tick();
    wait_drained();

    repeat (30) @(posedge clk);
    mismatches += expected_events.size();
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
